// ===== rtl/core/svpd_pkg.sv =====
package svpd_pkg;

    // input and result widths
    localparam int IN_W   = 16;
    localparam int DUTY_W = 17;

    // projections in Q.30, one sign bit above the largest magnitude
    localparam int PROJ_W = 33;
    // active times in Q.30 (non-negative) and their sum
    localparam int TIME_W = 32;
    localparam int SUM_W  = TIME_W + 1;

    // scale factor quotient, divider cut into stages
    localparam int QUOT_W            = 16;
    localparam int DIV_BITS_PER_STG  = 2;
    localparam int DIV_STAGES        = QUOT_W / DIV_BITS_PER_STG;

    // sqrt(3)/2 in Q0.16
    localparam logic signed [16:0] SQRT3_HALF_Q16 = 17'sd56756;

    localparam logic [SUM_W-1:0]  PERIOD_Q30 = SUM_W'(64'h4000_0000);
    localparam logic [DUTY_W-1:0] FULL_Q16   = DUTY_W'(65536);
    localparam logic [DUTY_W-1:0] HALF_Q16   = DUTY_W'(32768);

    typedef logic [2:0] t_sector;

    // sector codes: bit0 u1 > 0, bit1 u2 > 0, bit2 u3 > 0
    localparam t_sector SEC_NONE = 3'd0;
    localparam t_sector SEC_P1   = 3'd1;
    localparam t_sector SEC_P2   = 3'd2;
    localparam t_sector SEC_P1P2 = 3'd3;
    localparam t_sector SEC_P3   = 3'd4;
    localparam t_sector SEC_P1P3 = 3'd5;
    localparam t_sector SEC_P2P3 = 3'd6;
    localparam t_sector SEC_ALL  = 3'd7;

    typedef struct packed {
        logic [TIME_W-1:0] tx;
        logic [TIME_W-1:0] ty;
        logic [SUM_W-1:0]  sum;
        t_sector           sec;
        logic              ovm;
    } t_proj;

    typedef struct packed {
        logic [TIME_W-1:0] tx;
        logic [TIME_W-1:0] ty;
        logic [DUTY_W-1:0] k;
        t_sector           sec;
        logic              ovm;
    } t_scaled;

endpackage

// ===== rtl/core/svpd_proj.sv =====
module svpd_proj (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    output logic                                o_stall,
    input  logic signed [svpd_pkg::IN_W-1:0]    i_v_alpha,
    input  logic signed [svpd_pkg::IN_W-1:0]    i_v_beta,
    output logic                                o_vld,
    input  logic                                i_stall,
    output svpd_pkg::t_proj                     o_data
);

    localparam int PW = svpd_pkg::PROJ_W;
    localparam int TW = svpd_pkg::TIME_W;
    localparam int SW = svpd_pkg::SUM_W;

    logic [2:0] r_vld;
    logic [3:0] w_adv;

    // stage 1: alpha * K
    logic signed [PW-1:0]              r1_m;
    logic signed [svpd_pkg::IN_W-1:0]  r1_be;
    logic signed [PW-1:0]              n1_m;

    // stage 2: projections and sector
    logic signed [PW-1:0] r2_u1, r2_u2, r2_u3;
    svpd_pkg::t_sector    r2_sec;
    logic signed [PW-1:0] n2_u1, n2_u2, n2_u3, w_bh;
    svpd_pkg::t_sector    n2_sec;

    // stage 3: active times, sum, clamp test
    svpd_pkg::t_proj      r3_data;
    svpd_pkg::t_proj      n3_data;
    logic signed [PW-1:0] w_sx, w_sy;

    always_comb begin
        w_adv[3] = !i_stall;
        for (int k = 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[0];
    assign o_vld   = r_vld[2];
    assign o_data  = r3_data;

    assign n1_m = PW'(i_v_alpha) * PW'(svpd_pkg::SQRT3_HALF_Q16);

    assign n2_u1 = PW'($signed({r1_be, 16'h0000}));
    assign w_bh  = PW'($signed({r1_be, 15'h0000}));
    assign n2_u2 = -r1_m - w_bh;
    assign n2_u3 = r1_m - w_bh;
    assign n2_sec = {(!n2_u3[PW-1] && (n2_u3 != '0)),
                     (!n2_u2[PW-1] && (n2_u2 != '0)),
                     (!n2_u1[PW-1] && (n2_u1 != '0))};

    always_comb begin
        unique case (r2_sec)
            svpd_pkg::SEC_P1P3: begin w_sx = r2_u3;  w_sy = r2_u1;  end
            svpd_pkg::SEC_P1:   begin w_sx = -r2_u3; w_sy = -r2_u2; end
            svpd_pkg::SEC_P1P2: begin w_sx = r2_u1;  w_sy = r2_u2;  end
            svpd_pkg::SEC_P2:   begin w_sx = -r2_u1; w_sy = -r2_u3; end
            svpd_pkg::SEC_P2P3: begin w_sx = r2_u2;  w_sy = r2_u3;  end
            svpd_pkg::SEC_P3:   begin w_sx = -r2_u2; w_sy = -r2_u1; end
            default:            begin w_sx = '0;     w_sy = '0;     end
        endcase
        n3_data.tx  = w_sx[PW-1] ? '0 : w_sx[TW-1:0];
        n3_data.ty  = w_sy[PW-1] ? '0 : w_sy[TW-1:0];
        n3_data.sum = SW'(n3_data.tx) + SW'(n3_data.ty);
        n3_data.sec = r2_sec;
        n3_data.ovm = n3_data.sum > svpd_pkg::PERIOD_Q30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_vld;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_m  <= n1_m;
            r1_be <= i_v_beta;
        end
        if (w_adv[1]) begin
            r2_u1  <= n2_u1;
            r2_u2  <= n2_u2;
            r2_u3  <= n2_u3;
            r2_sec <= n2_sec;
        end
        if (w_adv[2]) begin
            r3_data <= n3_data;
        end
    end

endmodule

// ===== rtl/core/svpd_div.sv =====
module svpd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_stall,
    input  svpd_pkg::t_proj    i_data,
    output logic               o_vld,
    input  logic               i_stall,
    output svpd_pkg::t_scaled  o_data
);

    localparam int NS  = svpd_pkg::DIV_STAGES;
    localparam int BPS = svpd_pkg::DIV_BITS_PER_STG;
    localparam int QW  = svpd_pkg::QUOT_W;
    localparam int SW  = svpd_pkg::SUM_W;

    logic [NS-1:0]   r_vld;
    logic [NS:0]     w_adv;
    svpd_pkg::t_proj r_data [NS];
    logic [SW-1:0]   r_rem  [NS];
    logic [QW-1:0]   r_quo  [NS];

    always_comb begin
        w_adv[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[0];
    assign o_vld   = r_vld[NS-1];

    // restoring division of 2^46 by the sum; first partial remainder is 2^30
    for (genvar g = 0; g < NS; g++) begin : g_stg
        logic            w_vld_i;
        svpd_pkg::t_proj w_dat_i;
        logic [SW-1:0]   w_rem_i;
        logic [QW-1:0]   w_quo_i;
        logic [SW-1:0]   n_rem;
        logic [QW-1:0]   n_quo;

        if (g == 0) begin : g_first
            assign w_vld_i = i_vld;
            assign w_dat_i = i_data;
            assign w_rem_i = svpd_pkg::PERIOD_Q30;
            assign w_quo_i = '0;
        end else begin : g_next
            assign w_vld_i = r_vld[g-1];
            assign w_dat_i = r_data[g-1];
            assign w_rem_i = r_rem[g-1];
            assign w_quo_i = r_quo[g-1];
        end

        always_comb begin
            logic [SW:0]   v_sh;
            logic [SW-1:0] v_rem;
            logic [QW-1:0] v_quo;
            v_rem = w_rem_i;
            v_quo = w_quo_i;
            for (int b = 0; b < BPS; b++) begin
                v_sh = {v_rem, 1'b0};
                if (v_sh >= {1'b0, w_dat_i.sum}) begin
                    v_rem = SW'(v_sh - {1'b0, w_dat_i.sum});
                    v_quo = {v_quo[QW-2:0], 1'b1};
                end else begin
                    v_rem = v_sh[SW-1:0];
                    v_quo = {v_quo[QW-2:0], 1'b0};
                end
            end
            n_rem = v_rem;
            n_quo = v_quo;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (w_adv[g]) begin
                r_vld[g] <= w_vld_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[g]) begin
                r_data[g] <= w_dat_i;
                r_rem[g]  <= n_rem;
                r_quo[g]  <= n_quo;
            end
        end
    end

    always_comb begin
        o_data.tx  = r_data[NS-1].tx;
        o_data.ty  = r_data[NS-1].ty;
        o_data.sec = r_data[NS-1].sec;
        o_data.ovm = r_data[NS-1].ovm;
        o_data.k   = r_data[NS-1].ovm ? svpd_pkg::DUTY_W'(r_quo[NS-1])
                                      : svpd_pkg::FULL_Q16;
    end

endmodule

// ===== rtl/core/svpd_duty.sv =====
module svpd_duty (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    output logic                           o_stall,
    input  svpd_pkg::t_scaled              i_data,
    output logic                           o_vld,
    input  logic                           i_stall,
    output logic [svpd_pkg::DUTY_W-1:0]    o_duty_a,
    output logic [svpd_pkg::DUTY_W-1:0]    o_duty_b,
    output logic [svpd_pkg::DUTY_W-1:0]    o_duty_c,
    output svpd_pkg::t_sector              o_sector_code,
    output logic [svpd_pkg::DUTY_W-1:0]    o_scale_factor,
    output logic                           o_overmodulated
);

    localparam int DW = svpd_pkg::DUTY_W;
    localparam int TW = svpd_pkg::TIME_W;
    localparam int PW = TW + svpd_pkg::QUOT_W;

    logic [1:0] r_vld;
    logic [2:0] w_adv;

    // stage 1: scaled Q0.16 times
    logic [DW-1:0]     r1_txq, r1_tyq, r1_k;
    svpd_pkg::t_sector r1_sec;
    logic              r1_ovm;
    logic [PW-1:0]     w_px, w_py;
    logic [DW-1:0]     n1_txq, n1_tyq;

    // stage 2: zero-time split and phase routing
    logic [DW-1:0]     r2_da, r2_db, r2_dc, r2_k;
    svpd_pkg::t_sector r2_sec;
    logic              r2_ovm;
    logic [DW-1:0]     w_sum, w_h, w_lead, w_mid;
    logic [DW-1:0]     n2_da, n2_db, n2_dc;

    always_comb begin
        w_adv[2] = !i_stall;
        for (int k = 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[0];
    assign o_vld   = r_vld[1];

    // times never exceed the sum, so the clamped products stay below 2^47
    assign w_px   = PW'(i_data.tx) * PW'(i_data.k[svpd_pkg::QUOT_W-1:0]);
    assign w_py   = PW'(i_data.ty) * PW'(i_data.k[svpd_pkg::QUOT_W-1:0]);
    assign n1_txq = i_data.ovm ? w_px[46:30] : i_data.tx[30:14];
    assign n1_tyq = i_data.ovm ? w_py[46:30] : i_data.ty[30:14];

    assign w_sum  = r1_txq + r1_tyq;
    assign w_h    = DW'(svpd_pkg::FULL_Q16 - w_sum) >> 1;
    assign w_lead = w_sum + w_h;
    assign w_mid  = r1_tyq + w_h;

    always_comb begin
        unique case (r1_sec)
            svpd_pkg::SEC_P1P3: begin n2_da = w_lead; n2_db = w_mid;  n2_dc = w_h;    end
            svpd_pkg::SEC_P1:   begin n2_da = w_mid;  n2_db = w_lead; n2_dc = w_h;    end
            svpd_pkg::SEC_P1P2: begin n2_da = w_h;    n2_db = w_lead; n2_dc = w_mid;  end
            svpd_pkg::SEC_P2:   begin n2_da = w_h;    n2_db = w_mid;  n2_dc = w_lead; end
            svpd_pkg::SEC_P2P3: begin n2_da = w_mid;  n2_db = w_h;    n2_dc = w_lead; end
            svpd_pkg::SEC_P3:   begin n2_da = w_lead; n2_db = w_h;    n2_dc = w_mid;  end
            default: begin
                // zero vector: all phases at half period
                n2_da = svpd_pkg::HALF_Q16;
                n2_db = svpd_pkg::HALF_Q16;
                n2_dc = svpd_pkg::HALF_Q16;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_vld;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_txq <= n1_txq;
            r1_tyq <= n1_tyq;
            r1_k   <= i_data.k;
            r1_sec <= i_data.sec;
            r1_ovm <= i_data.ovm;
        end
        if (w_adv[1]) begin
            r2_da  <= n2_da;
            r2_db  <= n2_db;
            r2_dc  <= n2_dc;
            r2_k   <= r1_k;
            r2_sec <= r1_sec;
            r2_ovm <= r1_ovm;
        end
    end

    assign o_duty_a        = r2_da;
    assign o_duty_b        = r2_db;
    assign o_duty_c        = r2_dc;
    assign o_sector_code   = r2_sec;
    assign o_scale_factor  = r2_k;
    assign o_overmodulated = r2_ovm;

endmodule

// ===== rtl/core/space_vector_pwm_duty.sv =====
// Space vector PWM duty generator, seven-segment pattern with centered zero vectors.
// Pipeline: 3 projection stages, 8 divider stages at 2 quotient bits each,
// and 2 scaling/duty stages.
// Throughput: one request per cycle; a stall only backs up once every stage is full.
// Reset (i_rst_n, synchronous, active low) clears the valid bits of all stages.
module space_vector_pwm_duty (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [svpd_pkg::IN_W-1:0]    i_v_alpha,
    input  logic signed [svpd_pkg::IN_W-1:0]    i_v_beta,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [svpd_pkg::DUTY_W-1:0]         o_duty_a,
    output logic [svpd_pkg::DUTY_W-1:0]         o_duty_b,
    output logic [svpd_pkg::DUTY_W-1:0]         o_duty_c,
    output logic [2:0]                          o_sector_code,
    output logic [svpd_pkg::DUTY_W-1:0]         o_scale_factor,
    output logic                                o_overmodulated
);

    // Each stage advances when it is empty or the stage after it advances,
    // so bubbles close up and a held result does not block new requests
    // until the pipeline is full.

    logic              w_proj_vld, w_proj_stall;
    svpd_pkg::t_proj   w_proj;
    logic              w_div_vld, w_div_stall;
    svpd_pkg::t_scaled w_div;

    // projections u1..u3 (Q.30), sector from their signs, active times and sum
    svpd_proj u_proj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (i_valid),
        .o_stall   (o_stall),
        .i_v_alpha (i_v_alpha),
        .i_v_beta  (i_v_beta),
        .o_vld     (w_proj_vld),
        .i_stall   (w_proj_stall),
        .o_data    (w_proj)
    );

    // scale factor k = floor(2^46 / sum), used only when sum exceeds a period
    svpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_proj_vld),
        .o_stall (w_proj_stall),
        .i_data  (w_proj),
        .o_vld   (w_div_vld),
        .i_stall (w_div_stall),
        .o_data  (w_div)
    );

    // Q0.16 times, zero-time split, phase routing; last stage is the output register
    svpd_duty u_duty (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (w_div_vld),
        .o_stall         (w_div_stall),
        .i_data          (w_div),
        .o_vld           (o_valid),
        .i_stall         (i_stall),
        .o_duty_a        (o_duty_a),
        .o_duty_b        (o_duty_b),
        .o_duty_c        (o_duty_c),
        .o_sector_code   (o_sector_code),
        .o_scale_factor  (o_scale_factor),
        .o_overmodulated (o_overmodulated)
    );

endmodule

// ===== sim/tb_space_vector_pwm_duty.sv =====
`timescale 1ns / 1ps

// Testbench for the space vector PWM duty generator.
// A scoreboard predicts the three duties, the sector, the scale factor and
// the overmodulation flag for every accepted request. It then compares them
// in order with the results that the block returns.
module tb_space_vector_pwm_duty;

    localparam int          IN_W   = svpd_pkg::IN_W;
    localparam int          DUTY_W = svpd_pkg::DUTY_W;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          DRAIN_CYCLES = 30;    // well past the pipeline latency

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        svpd_pkg::t_sector sector_code;
        logic [DUTY_W-1:0] scale_factor;
        logic              overmodulated;
    } t_duty_result;

    // Scoreboard: holds the predicted duties in request order.
    class t_duty_board;
        t_duty_result pending_duties[$];
        int unsigned  errors = 0;

        // Bit-exact duty computation. Projections are Q.30 and times are Q0.16.
        function t_duty_result predict_duties(logic signed [IN_W-1:0] alpha,
                                              logic signed [IN_W-1:0] beta);
            longint            al, be, p1, p2, p3, sx, sy;
            longint unsigned   tx, ty, sum, k, txq, tyq, h, lead, mid;
            svpd_pkg::t_sector sec;
            t_duty_result      r;
            al = longint'(alpha);
            be = longint'(beta);
            p1 = be * 65536;
            p2 = -al * longint'(svpd_pkg::SQRT3_HALF_Q16) - be * 32768;
            p3 = al * longint'(svpd_pkg::SQRT3_HALF_Q16) - be * 32768;
            sec = {p3 > 0, p2 > 0, p1 > 0};
            r.sector_code   = sec;
            r.scale_factor  = svpd_pkg::FULL_Q16;
            r.overmodulated = 1'b0;
            case (sec)
                svpd_pkg::SEC_P1P3: begin sx = p3;  sy = p1;  end
                svpd_pkg::SEC_P1:   begin sx = -p3; sy = -p2; end
                svpd_pkg::SEC_P1P2: begin sx = p1;  sy = p2;  end
                svpd_pkg::SEC_P2:   begin sx = -p1; sy = -p3; end
                svpd_pkg::SEC_P2P3: begin sx = p2;  sy = p3;  end
                svpd_pkg::SEC_P3:   begin sx = -p2; sy = -p1; end
                default: begin
                    // zero vector: centered half duty on all phases
                    r.duty_a = svpd_pkg::HALF_Q16;
                    r.duty_b = svpd_pkg::HALF_Q16;
                    r.duty_c = svpd_pkg::HALF_Q16;
                    return r;
                end
            endcase
            tx  = (sx < 0) ? 64'd0 : unsigned'(sx);
            ty  = (sy < 0) ? 64'd0 : unsigned'(sy);
            sum = tx + ty;
            k   = 64'd65536;
            if (sum > 64'h4000_0000) begin
                // clamp to the hexagon edge
                k   = (64'd1 << 46) / sum;
                txq = (tx * k) >> 30;
                tyq = (ty * k) >> 30;
                r.overmodulated = 1'b1;
            end else begin
                txq = tx >> 14;
                tyq = ty >> 14;
            end
            h    = (64'd65536 - txq - tyq) >> 1;
            lead = txq + tyq + h;
            mid  = tyq + h;
            r.scale_factor = DUTY_W'(k);
            case (sec)
                svpd_pkg::SEC_P1P3: begin
                    r.duty_a = DUTY_W'(lead); r.duty_b = DUTY_W'(mid);  r.duty_c = DUTY_W'(h);
                end
                svpd_pkg::SEC_P1: begin
                    r.duty_a = DUTY_W'(mid);  r.duty_b = DUTY_W'(lead); r.duty_c = DUTY_W'(h);
                end
                svpd_pkg::SEC_P1P2: begin
                    r.duty_a = DUTY_W'(h);    r.duty_b = DUTY_W'(lead); r.duty_c = DUTY_W'(mid);
                end
                svpd_pkg::SEC_P2: begin
                    r.duty_a = DUTY_W'(h);    r.duty_b = DUTY_W'(mid);  r.duty_c = DUTY_W'(lead);
                end
                svpd_pkg::SEC_P2P3: begin
                    r.duty_a = DUTY_W'(mid);  r.duty_b = DUTY_W'(h);    r.duty_c = DUTY_W'(lead);
                end
                default: begin
                    r.duty_a = DUTY_W'(lead); r.duty_b = DUTY_W'(h);    r.duty_c = DUTY_W'(mid);
                end
            endcase
            return r;
        endfunction

        function void note_request(logic signed [IN_W-1:0] alpha,
                                   logic signed [IN_W-1:0] beta);
            pending_duties.push_back(predict_duties(alpha, beta));
        endfunction

        function void check_field(string name, longint unsigned want,
                                  longint unsigned seen);
            if (want != seen) begin
                $error("%s: expected %0d, actual %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(t_duty_result seen);
            t_duty_result want;
            if (pending_duties.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = pending_duties.pop_front();
            check_field("duty_a", longint'(want.duty_a), longint'(seen.duty_a));
            check_field("duty_b", longint'(want.duty_b), longint'(seen.duty_b));
            check_field("duty_c", longint'(want.duty_c), longint'(seen.duty_c));
            check_field("sector_code", longint'(want.sector_code),
                        longint'(seen.sector_code));
            check_field("scale_factor", longint'(want.scale_factor),
                        longint'(seen.scale_factor));
            check_field("overmodulated", longint'(want.overmodulated),
                        longint'(seen.overmodulated));
        endfunction

        function int pending();
            return pending_duties.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [IN_W-1:0]  i_v_alpha = '0;
    logic signed [IN_W-1:0]  i_v_beta = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [DUTY_W-1:0]       o_duty_a;
    logic [DUTY_W-1:0]       o_duty_b;
    logic [DUTY_W-1:0]       o_duty_c;
    logic [2:0]              o_sector_code;
    logic [DUTY_W-1:0]       o_scale_factor;
    logic                    o_overmodulated;

    t_duty_board board = new();
    int unsigned cycle_count = 0;
    bit          sender_gaps = 1'b0;   // random idle bursts on the request side
    bit          result_stalls = 1'b0; // random stall bursts on the result side

    space_vector_pwm_duty u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_v_alpha       (i_v_alpha),
        .i_v_beta        (i_v_beta),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_duty_a        (o_duty_a),
        .o_duty_b        (o_duty_b),
        .o_duty_c        (o_duty_c),
        .o_sector_code   (o_sector_code),
        .o_scale_factor  (o_scale_factor),
        .o_overmodulated (o_overmodulated)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Both channels are sampled at the edge where the handshake completes.
    // The request is noted before the result is checked.
    always @(posedge i_clk) begin : monitor
        t_duty_result seen;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                board.note_request(i_v_alpha, i_v_beta);
            if (o_valid && !i_stall) begin
                seen.duty_a        = o_duty_a;
                seen.duty_b        = o_duty_b;
                seen.duty_c        = o_duty_c;
                seen.sector_code   = o_sector_code;
                seen.scale_factor  = o_scale_factor;
                seen.overmodulated = o_overmodulated;
                board.check_result(seen);
            end
        end
    end

    // Result side: random stall bursts while enabled.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (result_stalls && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Hold one request until it is taken. Called at a rising edge.
    task automatic send_request(input logic signed [IN_W-1:0] alpha,
                                input logic signed [IN_W-1:0] beta);
        i_valid   <= 1'b1;
        i_v_alpha <= alpha;
        i_v_beta  <= beta;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_burst();
        i_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge i_clk);
    endtask

    // Stop sending until every outstanding request has come back.
    task automatic drain_requests();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Random vector drawn from one of several regions of the plane.
    task automatic pick_vector(output logic signed [IN_W-1:0] alpha,
                               output logic signed [IN_W-1:0] beta);
        case ($urandom_range(0, 3))
            0: begin    // whole input range, mostly overmodulated
                alpha = IN_W'($urandom);
                beta  = IN_W'($urandom);
            end
            1: begin    // mostly linear region
                alpha = IN_W'(int'($urandom_range(0, 28000)) - 14000);
                beta  = IN_W'(int'($urandom_range(0, 28000)) - 14000);
            end
            2: begin    // around the hexagon edge
                alpha = IN_W'(int'($urandom_range(0, 40000)) - 20000);
                beta  = IN_W'(int'($urandom_range(0, 40000)) - 20000);
                if ($urandom_range(0, 1) == 0)
                    beta = IN_W'(int'($urandom_range(0, 4000)) + 14384) *
                           ($urandom_range(0, 1) ? 16'sd1 : -16'sd1);
            end
            default: begin  // tiny vectors and sector boundaries
                alpha = IN_W'(int'($urandom_range(0, 64)) - 32);
                beta  = IN_W'(int'($urandom_range(0, 64)) - 32);
                case ($urandom_range(0, 3))
                    0: alpha = '0;
                    1: beta = '0;
                    default: ;
                endcase
            end
        endcase
    endtask

    initial begin
        logic signed [IN_W-1:0] alpha, beta;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vector, axes, extremes, one vector per sector,
        // and an active sum exactly at one period.
        send_request(16'sd0, 16'sd0);
        send_request(16'sd0, 16'sd16384);       // sum equals the period
        send_request(16'sd0, -16'sd16384);      // sum equals the period
        send_request(16'sd0, 16'sd16385);       // just past the period
        send_request(16'sd16384, 16'sd0);
        send_request(16'sd32767, 16'sd0);
        send_request(-16'sd32768, 16'sd0);
        send_request(16'sd0, 16'sd32767);
        send_request(16'sd0, -16'sd32768);
        send_request(16'sd32767, 16'sd32767);
        send_request(-16'sd32768, -16'sd32768);
        send_request(16'sd32767, -16'sd32768);
        send_request(-16'sd32768, 16'sd32767);
        send_request(16'sd1, 16'sd0);
        send_request(-16'sd1, 16'sd0);
        send_request(16'sd0, 16'sd1);
        send_request(16'sd0, -16'sd1);
        send_request(16'sd8000, 16'sd4000);     // each of the six sectors
        send_request(16'sd0, 16'sd8000);
        send_request(-16'sd8000, 16'sd4000);
        send_request(-16'sd8000, -16'sd4000);
        send_request(16'sd0, -16'sd8000);
        send_request(16'sd8000, -16'sd4000);
        drain_requests();

        // Random: nine chunks with idling chosen per chunk, the last chunk
        // with none. The pipeline is drained once mid-run.
        for (int chunk = 0; chunk < 9; chunk++) begin
            if (chunk == 8) begin
                sender_gaps   = 1'b0;
                result_stalls = 1'b0;
            end else begin
                sender_gaps   = $urandom_range(0, 2) != 0;
                result_stalls = $urandom_range(0, 2) != 0;
            end
            for (int n = 0; n < 100; n++) begin
                if (sender_gaps && $urandom_range(0, 7) == 0)
                    idle_burst();
                pick_vector(alpha, beta);
                send_request(alpha, beta);
            end
            if (chunk == 4)
                drain_requests();
        end

        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/svpd_pkg.sv
rtl/core/svpd_proj.sv
rtl/core/svpd_div.sv
rtl/core/svpd_duty.sv
rtl/core/space_vector_pwm_duty.sv
sim/tb_space_vector_pwm_duty.sv
